// ===== hw/rtl/cubic_trajectory_point_top_defines.svh =====
// Assertion macros for the cubic trajectory point block.
// Included by the top level; depends on nothing else.
`ifndef CUBIC_TRAJECTORY_POINT_TOP_DEFINES_SVH
`define CUBIC_TRAJECTORY_POINT_TOP_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define CTP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle
`define CTP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ctp_pkg.sv =====
// Shared widths, register indexes and types for the cubic trajectory point block.
// No dependencies; every other file but the defines header imports it.
package ctp_pkg;

    localparam int TIME_W     = 32;
    localparam int POS_W      = 32;
    localparam int MUL_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_TIME = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_TIME   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_POS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_VEL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_END_POS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_END_VEL    = 3'd5;

    localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;

    // Where a sample falls relative to the segment
    typedef enum logic [1:0] {
        RG_BEFORE = 2'd0,
        RG_INSIDE = 2'd1,
        RG_AFTER  = 2'd2
    } t_region;

endpackage

// ===== hw/rtl/ctp_in_if.sv =====
// Sample time channel: valid/ready handshake carrying one sample tick per word.
// Depends on ctp_pkg for the time width.
interface ctp_in_if import ctp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] sample_time;

    modport source (output valid, output sample_time, input ready);
    modport sink   (input valid, input sample_time, output ready);
endinterface

// ===== hw/rtl/ctp_out_if.sv =====
// Result channel: valid/ready handshake carrying position and clip flag per word.
// Depends on ctp_pkg for the position width.
interface ctp_out_if import ctp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] position;
    logic                    clipped;

    modport source (output valid, output position, output clipped, input ready);
    modport sink   (input valid, input position, input clipped, output ready);
endinterface

// ===== hw/rtl/ctp_mul.sv =====
// Two-stage signed-by-unsigned multiplier: 32-bit chunk products, then a shifted sum.
// Depends on ctp_pkg for the chunk width.
module ctp_mul import ctp_pkg::*; #(
    parameter int AW = 64
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [AW-1:0]   i_a,
    input  logic [MUL_W-1:0]       i_b,
    output logic signed [AW+MUL_W-1:0] o_p
);

    localparam int NC  = (AW + MUL_W - 1) / MUL_W;
    localparam int AXW = NC * MUL_W;
    localparam int SW  = AXW + MUL_W;
    localparam int PPW = 2 * MUL_W + 2;

    logic signed [AXW-1:0]         w_ax;
    logic signed [PPW-1:0]         r_pp [NC];
    logic signed [SW-1:0]          w_acc;
    logic signed [AW+MUL_W-1:0]    r_p;

    assign w_ax = AXW'(i_a);

    // Form one partial product per chunk; the top chunk carries the sign
    for (genvar j = 0; j < NC; j++) begin : g_pp
        logic [MUL_W-1:0]      w_chunk;
        logic signed [PPW-1:0] w_pp;

        assign w_chunk = w_ax[MUL_W*j +: MUL_W];

        if (j == NC - 1) begin : g_top
            logic signed [2*MUL_W:0] w_ps;
            assign w_ps = $signed(w_chunk) * $signed({1'b0, i_b});
            assign w_pp = PPW'(w_ps);
        end else begin : g_low
            logic [2*MUL_W-1:0] w_pu;
            assign w_pu = w_chunk * i_b;
            assign w_pp = $signed({2'b00, w_pu});
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pp[j] <= w_pp;
            end
        end
    end

    // Sum the shifted partial products
    always_comb begin
        w_acc = '0;
        for (int j = 0; j < NC; j++) begin
            w_acc = w_acc + (SW'(r_pp[j]) <<< (MUL_W * j));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= w_acc[AW+MUL_W-1:0];
        end
    end

    assign o_p = r_p;

endmodule

// ===== hw/rtl/ctp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a side word that rides along.
// The caller must hold the divisor static; the block does not enforce it. Depends on ctp_pkg.
module ctp_div import ctp_pkg::*; #(
    parameter int NW = 166,
    parameter int DW = 97,
    parameter int QB = 67,
    parameter int SW = 68
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic [QB-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    logic [NW-1:0] r_rem  [QB];
    logic [QB-1:0] r_quo  [QB];
    logic [SW-1:0] r_side [QB];

    for (genvar k = 0; k < QB; k++) begin : g_step
        localparam int SH = QB - 1 - k;

        logic [NW-1:0] w_rin;
        logic [QB-1:0] w_qin;
        logic [SW-1:0] w_sin;
        logic [NW-1:0] w_dsh;
        logic          w_ge;

        if (k == 0) begin : g_first
            assign w_rin = i_num;
            assign w_qin = '0;
            assign w_sin = i_side;
        end else begin : g_next
            assign w_rin = r_rem[k-1];
            assign w_qin = r_quo[k-1];
            assign w_sin = r_side[k-1];
        end

        // Try to subtract the divisor at this bit weight
        assign w_dsh = NW'(i_den) << SH;
        assign w_ge  = (w_rin >= w_dsh);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? (w_rin - w_dsh) : w_rin;
                r_quo[k]  <= w_qin | (QB'(w_ge) << SH);
                r_side[k] <= w_sin;
            end
        end
    end

    assign o_quo  = r_quo[QB-1];
    assign o_side = r_side[QB-1];

endmodule

// ===== hw/rtl/ctp_skid.sv =====
// Output register with a skid stage, so the pipeline enable depends only on a flop.
// Depends on ctp_pkg.
module ctp_skid import ctp_pkg::*; #(
    parameter int W = 33
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic [W-1:0] i_data,
    output logic         o_in_ready,
    output logic         o_valid,
    output logic [W-1:0] o_data,
    input  logic         i_ready
);

    logic         r_out_v;
    logic [W-1:0] r_out_d;
    logic         r_sk_v;
    logic [W-1:0] r_sk_d;
    logic         w_free;

    assign w_free     = !r_out_v || i_ready;
    assign o_in_ready = !r_sk_v;

    // Advance the output word, park an incoming word when the output is held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_sk_v  <= 1'b0;
        end else if (w_free) begin
            if (r_sk_v) begin
                r_out_v <= 1'b1;
                r_sk_v  <= 1'b0;
            end else begin
                r_out_v <= i_valid;
            end
        end else if (i_valid && !r_sk_v) begin
            r_sk_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free) begin
            r_out_d <= r_sk_v ? r_sk_d : i_data;
        end
        if (!w_free && i_valid && !r_sk_v) begin
            r_sk_d <= i_data;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out_d;

endmodule

// ===== hw/rtl/cubic_trajectory_point_top.sv =====
// Throughput: one word per cycle unless the output stalls; the 67-stage restoring
// divider, one quotient bit per stage, sets the depth. A skid stage at the output
// keeps ready tied to a flop.
// Reset (synchronous, active low) clears all configuration registers to zero and
// empties the pipeline and output stage; there is no clearing pass.
// Depends on ctp_pkg, ctp_in_if, ctp_out_if, ctp_mul, ctp_div, ctp_skid and the defines header.
`include "cubic_trajectory_point_top_defines.svh"

module cubic_trajectory_point_top import ctp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    ctp_in_if.sink                i_in,
    ctp_out_if.source             o_out
);

    localparam int D_W   = POS_W + 1;
    localparam int C1_W  = POS_W + 2;
    localparam int C2_W  = POS_W + 1;
    localparam int CP_W  = 67;
    localparam int CQ_W  = 66;
    localparam int G_W   = 100;
    localparam int W_W   = G_W + 2 * TIME_W;
    localparam int T2_W  = 2 * TIME_W;
    localparam int T3_W  = 3 * TIME_W;
    localparam int E_W   = T3_W + 1;
    localparam int M_W   = W_W + 2;
    localparam int QB    = 67;
    localparam int A_W   = POS_W + TIME_W + 1;
    localparam int SUM_W = QB + 3;
    localparam int SD_W  = A_W + 3;
    localparam int VLD_N = 12 + QB;

    // Configuration registers
    logic [TIME_W-1:0]       r_t0;
    logic [TIME_W-1:0]       r_tf;
    logic signed [POS_W-1:0] r_x0;
    logic signed [POS_W-1:0] r_v0;
    logic signed [POS_W-1:0] r_xf;
    logic signed [POS_W-1:0] r_vf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t0 <= '0;
            r_tf <= '0;
            r_x0 <= '0;
            r_v0 <= '0;
            r_xf <= '0;
            r_vf <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START_TIME: r_t0 <= i_cfg_wdata;
                CFG_END_TIME:   r_tf <= i_cfg_wdata;
                CFG_START_POS:  r_x0 <= $signed(i_cfg_wdata);
                CFG_START_VEL:  r_v0 <= $signed(i_cfg_wdata);
                CFG_END_POS:    r_xf <= $signed(i_cfg_wdata);
                CFG_END_VEL:    r_vf <= $signed(i_cfg_wdata);
                default: ;
            endcase
        end
    end

    // Segment coefficients, computed from the configuration registers through registered multipliers
    logic [TIME_W-1:0]         w_ct;
    logic signed [D_W-1:0]     w_cd;
    logic signed [C1_W-1:0]    w_c1;
    logic signed [C2_W-1:0]    w_c2;
    logic signed [T2_W:0]      w_t2x;
    logic signed [C1_W+MUL_W-1:0] w_p1;
    logic signed [C2_W+MUL_W-1:0] w_q1;
    logic signed [CP_W-1:0]    r_cp;
    logic signed [CQ_W-1:0]    r_cq;
    logic signed [T3_W:0]      w_t3x;
    logic signed [CP_W+MUL_W-1:0] w_pt;
    logic [T3_W-1:0]           w_t3;
    logic [E_W-1:0]            w_e;

    assign w_ct = r_tf - r_t0;
    assign w_cd = D_W'(r_xf) - D_W'(r_x0);
    assign w_c1 = C1_W'(r_v0) + C1_W'(r_v0) + C1_W'(r_vf);
    assign w_c2 = C2_W'(r_v0) + C2_W'(r_vf);

    ctp_mul #(.AW(TIME_W + 1)) u_mul_t2 (
        .i_clk(i_clk), .i_en(1'b1), .i_a($signed({1'b0, w_ct})), .i_b(w_ct), .o_p(w_t2x)
    );
    ctp_mul #(.AW(C1_W)) u_mul_p1 (
        .i_clk(i_clk), .i_en(1'b1), .i_a(w_c1), .i_b(w_ct), .o_p(w_p1)
    );
    ctp_mul #(.AW(C2_W)) u_mul_q1 (
        .i_clk(i_clk), .i_en(1'b1), .i_a(w_c2), .i_b(w_ct), .o_p(w_q1)
    );

    // p = 3*(xf-x0) - (2*v0+vf)*T, q = (v0+vf)*T - 2*(xf-x0)
    always_ff @(posedge i_clk) begin
        r_cp <= CP_W'(w_cd) + CP_W'(w_cd) + CP_W'(w_cd) - CP_W'(w_p1);
        r_cq <= CQ_W'(w_q1) - CQ_W'(w_cd) - CQ_W'(w_cd);
    end

    ctp_mul #(.AW(T2_W + 1)) u_mul_t3 (
        .i_clk(i_clk), .i_en(1'b1), .i_a($signed({1'b0, w_t2x[T2_W-1:0]})), .i_b(w_ct),
        .o_p(w_t3x)
    );
    ctp_mul #(.AW(CP_W)) u_mul_pt (
        .i_clk(i_clk), .i_en(1'b1), .i_a(r_cp), .i_b(w_ct), .o_p(w_pt)
    );

    assign w_t3 = w_t3x[T3_W-1:0];
    assign w_e  = {w_t3, 1'b0};

    // Pipeline control
    logic             w_en;
    logic             w_acc;
    logic [VLD_N-1:0] r_vld;

    assign i_in.ready = w_en;
    assign w_acc      = i_in.valid && w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[VLD_N-2:0], w_acc};
        end
    end

    // Stage 1: offset into the segment and region; later stages delay them
    logic [TIME_W-1:0]     r_s_pipe  [1:9];
    t_region               r_rg_pipe [1:11];
    logic signed [A_W-1:0] r_a_pipe  [7:11];
    t_region               w_rg;

    always_comb begin
        if (i_in.sample_time < r_t0) begin
            w_rg = RG_BEFORE;
        end else if (i_in.sample_time >= r_tf) begin
            w_rg = RG_AFTER;
        end else begin
            w_rg = RG_INSIDE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s_pipe[1]  <= i_in.sample_time - r_t0;
            r_rg_pipe[1] <= w_rg;
            for (int i = 2; i <= 9; i++) begin
                r_s_pipe[i] <= r_s_pipe[i-1];
            end
            for (int i = 2; i <= 11; i++) begin
                r_rg_pipe[i] <= r_rg_pipe[i-1];
            end
        end
    end

    // Stages 5-6: q*s and v0*s
    logic signed [CQ_W+MUL_W-1:0]  w_qs;
    logic signed [POS_W+MUL_W-1:0] w_vs;

    ctp_mul #(.AW(CQ_W)) u_mul_qs (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_cq), .i_b(r_s_pipe[4]), .o_p(w_qs)
    );
    ctp_mul #(.AW(POS_W)) u_mul_vs (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_v0), .i_b(r_s_pipe[4]), .o_p(w_vs)
    );

    // Stage 7: g = p*T + q*s and the linear part x0 + v0*s; delay the linear part
    logic signed [G_W-1:0] r_g;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g         <= G_W'(w_pt) + G_W'(w_qs);
            r_a_pipe[7] <= A_W'(r_x0) + A_W'(w_vs);
            for (int i = 8; i <= 11; i++) begin
                r_a_pipe[i] <= r_a_pipe[i-1];
            end
        end
    end

    // Stages 8-11: W = g*s*s
    logic signed [G_W+MUL_W-1:0] w_gs;
    logic signed [W_W-1:0]       w_w;

    ctp_mul #(.AW(G_W)) u_mul_gs (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_g), .i_b(r_s_pipe[7]), .o_p(w_gs)
    );
    ctp_mul #(.AW(G_W + MUL_W)) u_mul_w (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_gs), .i_b(r_s_pipe[9]), .o_p(w_w)
    );

    // Stage 12: floor((2W + T^3) / 2T^3) as a magnitude division
    logic signed [M_W-1:0] w_m;
    logic                  w_neg;
    logic [M_W-1:0]        r_num;
    logic [SD_W-1:0]       r_side;

    assign w_m   = M_W'(w_w) + M_W'(w_w) + $signed(M_W'(w_t3));
    assign w_neg = w_m[M_W-1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_num  <= w_neg ? ($unsigned(-w_m) + M_W'(w_e) - M_W'(1)) : $unsigned(w_m);
            r_side <= {r_a_pipe[11], w_neg, r_rg_pipe[11]};
        end
    end

    logic [QB-1:0]   w_quo;
    logic [SD_W-1:0] w_dside;

    ctp_div #(.NW(M_W), .DW(E_W), .QB(QB), .SW(SD_W)) u_div (
        .i_clk(i_clk), .i_en(w_en), .i_num(r_num), .i_den(w_e), .i_side(r_side),
        .o_quo(w_quo), .o_side(w_dside)
    );

    // Final: add the rounded quotient to the linear part, saturate, pick by region
    logic signed [A_W-1:0]   w_fa;
    logic                    w_fneg;
    t_region                 w_frg;
    logic signed [SUM_W-1:0] w_fq;
    logic signed [SUM_W-1:0] w_sum;
    logic signed [POS_W-1:0] w_pos;
    logic                    w_clip;

    assign w_fa   = $signed(w_dside[SD_W-1:3]);
    assign w_fneg = w_dside[2];
    assign w_frg  = t_region'(w_dside[1:0]);
    assign w_fq   = w_fneg ? -$signed(SUM_W'(w_quo)) : $signed(SUM_W'(w_quo));
    assign w_sum  = w_fq + SUM_W'(w_fa);

    always_comb begin
        w_pos  = r_x0;
        w_clip = 1'b0;
        case (w_frg)
            RG_BEFORE: w_pos = r_x0;
            RG_AFTER:  w_pos = r_xf;
            RG_INSIDE: begin
                if (w_sum > SUM_W'(POS_MAX)) begin
                    w_pos  = POS_MAX;
                    w_clip = 1'b1;
                end else if (w_sum < SUM_W'(POS_MIN)) begin
                    w_pos  = POS_MIN;
                    w_clip = 1'b1;
                end else begin
                    w_pos = w_sum[POS_W-1:0];
                end
            end
            default: w_pos = r_x0;
        endcase
    end

    // Output register and skid stage
    logic [POS_W:0] w_odata;

    ctp_skid #(.W(POS_W + 1)) u_skid (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(r_vld[VLD_N-1]), .i_data({w_clip, w_pos}),
        .o_in_ready(w_en),
        .o_valid(o_out.valid), .o_data(w_odata), .i_ready(o_out.ready)
    );

    assign o_out.position = $signed(w_odata[POS_W-1:0]);
    assign o_out.clipped  = w_odata[POS_W];

    // Checks
    `CTP_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, !w_en, $stable(r_vld),
        "valid bits moved during a stall")
    `CTP_ASSERT_SAME(a_stall_has_out, i_clk, i_rst_n, !w_en, o_out.valid,
        "pipeline stalled with no word at the output")
    `CTP_ASSERT_NEXT(a_tail_lands, i_clk, i_rst_n, r_vld[VLD_N-1] && w_en, o_out.valid,
        "word leaving the divider was lost")
    `CTP_ASSERT_SAME(a_clip_value, i_clk, i_rst_n, o_out.valid && o_out.clipped,
        (o_out.position == POS_MAX) || (o_out.position == POS_MIN),
        "clipped word is not a saturation value")

endmodule

// ===== tb/cubic_trajectory_point_top_tb.sv =====
// Self-checking testbench for the cubic trajectory point block: drives sample words,
// predicts each position from a shadow copy of the segment registers and compares results.
// Depends on ctp_pkg, ctp_in_if, ctp_out_if and cubic_trajectory_point_top.
`timescale 1ns / 1ps

module cubic_trajectory_point_top_tb;
    import ctp_pkg::*;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic                    clipped;
    } t_point;

    localparam int LATENCY     = 80;
    localparam int CYCLE_LIMIT = 3000000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    ctp_in_if  in_if ();
    ctp_out_if out_if ();

    cubic_trajectory_point_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // Shadow copy of the segment registers
    logic [TIME_W-1:0]       seg_t0 = '0, seg_tf = '0;
    logic signed [POS_W-1:0] seg_x0 = '0, seg_v0 = '0, seg_xf = '0, seg_vf = '0;

    logic [TIME_W-1:0] sample_queue[$];
    t_point            point_queue[$];
    int                fail_count = 0;
    int                cycles = 0;
    logic              in_taken = 1'b0;
    int                burst_left = 0;
    int                gap_left = 0;
    int                stall_mode = 0;
    int                stall_count = 0;

    always #5 i_clk = ~i_clk;

    // Exact position on the segment: N / T^3 rounded half up, then saturated
    function automatic t_point point_at(input logic [TIME_W-1:0] t);
        logic signed [255:0] x0, v0, xf, vf, d, span, tau, span3, tau2;
        logic signed [255:0] p, q, n, m, e, quo, lim_hi, lim_lo;
        t_point r;
        r.clipped = 1'b0;
        if (t < seg_t0) begin
            r.position = seg_x0;
        end else if (t >= seg_tf) begin
            r.position = seg_xf;
        end else begin
            x0 = seg_x0; v0 = seg_v0; xf = seg_xf; vf = seg_vf;
            span = $signed({224'b0, seg_tf - seg_t0});
            tau = $signed({224'b0, t - seg_t0});
            d = xf - x0;
            span3 = span * span * span;
            tau2 = tau * tau;
            p = 3 * d - (2 * v0 + vf) * span;
            q = -2 * d + (v0 + vf) * span;
            n = x0 * span3 + v0 * tau * span3 + p * tau2 * span + q * tau2 * tau;
            m = 2 * n + span3;
            e = 2 * span3;
            if (m < 0) quo = -((-m + e - 1) / e);
            else quo = m / e;
            lim_hi = 256'sd2147483647;
            lim_lo = -lim_hi - 1;
            if (quo > lim_hi) begin
                r.position = POS_MAX;
                r.clipped = 1'b1;
            end else if (quo < lim_lo) begin
                r.position = POS_MIN;
                r.clipped = 1'b1;
            end else begin
                r.position = quo[31:0];
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycles, what);
        fail_count++;
    endtask

    // Predict on input words, check output words, watch the cycle limit
    always @(posedge i_clk) begin
        t_point got, want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end else begin
            in_taken <= in_if.valid && in_if.ready;
            if (i_rst_n && in_if.valid && in_if.ready)
                point_queue.insert(point_queue.size(), point_at(in_if.sample_time));
            if (i_rst_n && out_if.valid && out_if.ready) begin
                got.position = out_if.position;
                got.clipped = out_if.clipped;
                if (point_queue.size() == 0) begin
                    report_mismatch($sformatf("unexpected word pos=%h", got.position));
                end else begin
                    want = point_queue.pop_front();
                    if (got.position !== want.position)
                        report_mismatch($sformatf("position %h, want %h",
                            got.position, want.position));
                    if (got.clipped !== want.clipped)
                        report_mismatch($sformatf("clipped %b, want %b",
                            got.clipped, want.clipped));
                end
            end
        end
    end

    // Drive sample words in bursts with random gaps
    always @(negedge i_clk) begin
        if (i_rst_n && (!in_if.valid || in_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                in_if.valid <= 1'b0;
            end else if (sample_queue.size() > 0) begin
                in_if.valid <= 1'b1;
                in_if.sample_time <= sample_queue.pop_front();
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Stall the result side on one of four ready patterns, picked anew at random when its count runs out
    always @(negedge i_clk) begin
        if (stall_count == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_count = 50;
        end
        stall_count--;
        case (stall_mode)
            0: begin
                out_if.ready <= 1'b1;
            end
            1: begin
                out_if.ready <= 1'($urandom_range(0, 1));
            end
            2: begin
                out_if.ready <= (stall_count % 4) != 0;
            end
            default: begin
                out_if.ready <= ($urandom_range(0, 7) == 0);
            end
        endcase
    end

    // Queue one sample word for the driver
    task automatic add_sample(input logic [TIME_W-1:0] t);
        sample_queue.insert(sample_queue.size(), t);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= data;
        case (idx)
            CFG_START_TIME: seg_t0 = data;
            CFG_END_TIME:   seg_tf = data;
            CFG_START_POS:  seg_x0 = data;
            CFG_START_VEL:  seg_v0 = data;
            CFG_END_POS:    seg_xf = data;
            CFG_END_VEL:    seg_vf = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_segment(input logic [31:0] t0, input logic [31:0] tf,
                                 input logic [31:0] x0, input logic [31:0] v0,
                                 input logic [31:0] xf, input logic [31:0] vf);
        write_reg(CFG_START_TIME, t0);
        write_reg(CFG_END_TIME, tf);
        write_reg(CFG_START_POS, x0);
        write_reg(CFG_START_VEL, v0);
        write_reg(CFG_END_POS, xf);
        write_reg(CFG_END_VEL, vf);
    endtask

    // Hold the sender until every expected word has come, then let the pipe drain
    task automatic drain();
        do @(posedge i_clk);
        while (sample_queue.size() != 0 || in_if.valid || point_queue.size() != 0);
        repeat (LATENCY + 20) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 2000) - 1000;
            3: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [31:0] t0, span;
        in_if.valid = 1'b0;
        in_if.sample_time = '0;
        out_if.ready = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset segment: everything collapses to zero
        add_sample(32'd0);
        add_sample(32'hFFFF_FFFF);
        drain();

        // Plain segment: edges of the window and a few interior ticks
        write_segment(32'd100, 32'd200, 32'h0001_0000, 32'h0000_0800,
                      32'hFFF0_0000, 32'hFFFF_F000);
        add_sample(32'd0);
        add_sample(32'd99);
        add_sample(32'd100);
        add_sample(32'd101);
        add_sample(32'd150);
        add_sample(32'd199);
        add_sample(32'd200);
        add_sample(32'hFFFF_FFFF);
        drain();

        // Overflow: huge velocities over the longest segment saturate both ways
        write_segment(32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'h7FFF_FFFF);
        add_sample(32'd1);
        add_sample(32'h4000_0000);
        add_sample(32'hFFFF_FFFE);
        drain();
        write_reg(CFG_START_VEL, 32'h8000_0000);
        add_sample(32'd1);
        add_sample(32'h4000_0000);
        add_sample(32'hFFFF_FFFE);
        drain();
        write_segment(32'd0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'h8000_0000);
        add_sample(32'h2000_0000);
        add_sample(32'hC000_0000);
        drain();

        // Reversed and empty segments act as steps; unknown indexes are ignored
        write_segment(32'd500, 32'd100, 32'h1234_5678, 32'd7, 32'hEDCB_A988, 32'd9);
        write_reg(3'd6, 32'hDEAD_BEEF);
        write_reg(3'd7, 32'hFFFF_FFFF);
        add_sample(32'd50);
        add_sample(32'd100);
        add_sample(32'd300);
        add_sample(32'd500);
        add_sample(32'd600);
        drain();
        write_reg(CFG_END_TIME, 32'd500);
        add_sample(32'd499);
        add_sample(32'd500);
        drain();

        // Random segments, mostly sampled inside the window
        repeat (12) begin
            case ($urandom_range(0, 3))
                0: span = $urandom_range(1, 4);
                1: span = $urandom_range(5, 1000);
                2: span = $urandom_range(1000, 1 << 20);
                default: span = $urandom;
            endcase
            case ($urandom_range(0, 3))
                0: t0 = 32'd0;
                1: t0 = 32'hFFFF_FFFF - span;
                default: t0 = $urandom;
            endcase
            if ($urandom_range(0, 9) == 0) span = 32'hFFFF_FFFF - $urandom_range(0, 3);
            write_segment(t0, t0 + span, rand_value(), rand_value(), rand_value(),
                          rand_value());
            repeat (125) begin
                if ($urandom_range(0, 4) == 0)
                    add_sample($urandom);
                else
                    add_sample(t0 + $urandom_range(0, span - 1) % span);
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
